// ===== rtl/avgdx_pkg.sv =====
// Shared types and constants of the average directional index unit.
// Used by avgdx_div and average_directional_index_unit; depends on nothing.
package avgdx_pkg;

    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = 56;
    localparam int DI_W       = 48;
    localparam int ADX_W      = 23;
    localparam int DVD_W      = 80;
    localparam int DVS_W      = 56;
    localparam int CNT_W      = 7;

    localparam logic [SUM_W-1:0] SMOOTH_MAX  = {SUM_W{1'b1}};
    localparam logic [DI_W-1:0]  DI_MAX      = {DI_W{1'b1}};
    localparam logic [ADX_W-1:0] HUNDRED_FIX = ADX_W'(100 << FRAC_BITS);
    localparam logic [31:0]      INDEX_MAX   = 32'hFFFF_FFFF;
    localparam logic [10:0]      PERIOD_MIN  = 11'd2;
    localparam logic [10:0]      PERIOD_MAX  = 11'd1024;

    localparam logic REG_PERIOD   = 1'b0;
    localparam logic REG_UNSTABLE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/avgdx_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on avgdx_pkg for widths and the request and response structs.
module avgdx_div
    import avgdx_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? shifted - {1'b0, dvs_reg} : shifted;
                // The dividend register fills with quotient bits from the bottom.
                dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("divider started while busy");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while still busy");
    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held too long");

endmodule

// ===== rtl/average_directional_index_unit.sv =====
// Top level of the average directional index unit: bar intake, sequencer, output register.
// Depends on avgdx_pkg and on the serial divider avgdx_div.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  one price bar (high, low, close, first_bar flag)
// m_*       out  m_tvalid/m_tready  ADX value and bar index
// cfg_*     in   cfg_we             period and unstable_bars registers
//
// A bar needs at most seven divisions by the serial divider: three decays by the period,
// two DI divisions, one DX division and one ADX division; bars before the period need none.
// Reset is synchronous and clears the smoothed sums, the DX total, the ADX and the previous bar;
// it sets period to 14 and unstable_bars to 0.
// A held result stalls the sequencer only when the next result is ready.
module average_directional_index_unit
    import avgdx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // bar_high[31:0], bar_low[63:32], bar_close[95:64]
    input  logic        s_tuser,   // first_bar
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // adx_value[22:0], bar_index[54:23], zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_DECAY, S_ADD, S_CHK, S_MUL, S_DIDIV, S_SUM,
        S_DXDIV, S_ADXMUL, S_ADXDIV, S_FIN, S_AVGDIV, S_DONE, S_OUT
    } state_t;

    state_t           state_reg;
    logic [1:0]       k_reg;
    logic             issued_reg;
    logic [10:0]      period_reg;
    logic [9:0]       unstable_reg;
    logic [31:0]      hi_reg, lo_reg, cl_reg;
    logic [31:0]      last_high_reg, last_low_reg, last_close_reg;
    logic [31:0]      idx_reg, bar_counter_reg;
    logic [SUM_W-1:0] mdm_reg, pdm_reg, tr_reg;
    logic [DI_W-1:0]  mdi_reg, pdi_reg, absd_reg;
    logic [DI_W:0]    sum_reg;
    logic [33:0]      dx_total_reg;
    logic [ADX_W-1:0] adx_reg, dx_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [ADX_W-1:0] out_adx_reg;
    logic [31:0]      out_idx_reg;
    logic             m_tvalid_reg;

    logic [10:0]      p;
    logic [11:0]      p2m1, thr;
    logic signed [32:0] dp, dm;
    logic [31:0]      trv, t2, t3, tr_bar;
    logic [SUM_W:0]   add_m, add_p, add_t;
    logic [SUM_W-1:0] dec_sel;
    logic [62:0]      mul_a, prod;
    logic [DI_W:0]    di_sum;
    logic [DVD_W-1:0] q;
    logic [ADX_W-1:0] dx_cap;
    logic [DI_W-1:0]  di_cap;
    logic [33:0]      adx_mul;
    logic             div_state;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_comb begin
        if (period_reg < PERIOD_MIN) begin
            p = PERIOD_MIN;
        end else if (period_reg > PERIOD_MAX) begin
            p = PERIOD_MAX;
        end else begin
            p = period_reg;
        end
    end
    assign p2m1 = {p, 1'b0} - 12'd1;
    assign thr  = p2m1 + {2'b0, unstable_reg};

    // Directional movement and true range of the bar against the previous one.
    assign dp  = $signed({1'b0, hi_reg}) - $signed({1'b0, last_high_reg});
    assign dm  = $signed({1'b0, last_low_reg}) - $signed({1'b0, lo_reg});
    assign trv = (hi_reg >= lo_reg) ? hi_reg - lo_reg : 32'd0;
    assign t2  = (hi_reg >= last_close_reg) ? hi_reg - last_close_reg : last_close_reg - hi_reg;
    assign t3  = (lo_reg >= last_close_reg) ? lo_reg - last_close_reg : last_close_reg - lo_reg;
    always_comb begin
        tr_bar = trv;
        if (t2 > tr_bar) begin
            tr_bar = t2;
        end
        if (t3 > tr_bar) begin
            tr_bar = t3;
        end
    end
    assign add_m = {1'b0, mdm_reg} + {9'b0, dm[31:0], 16'b0};
    assign add_p = {1'b0, pdm_reg} + {9'b0, dp[31:0], 16'b0};
    assign add_t = {1'b0, tr_reg} + {9'b0, tr_bar, 16'b0};

    always_comb begin
        case (k_reg)
            2'd0:    mul_a = {7'b0, mdm_reg};
            2'd1:    mul_a = {7'b0, pdm_reg};
            default: mul_a = {15'b0, absd_reg};
        endcase
    end
    // Times 100 as 64 + 32 + 4.
    assign prod   = (mul_a << 6) + (mul_a << 5) + (mul_a << 2);
    assign di_sum = {1'b0, mdi_reg} + {1'b0, pdi_reg};

    // The ADX weight needs the full 34-bit product of ADX and the period less one.
    assign adx_mul = {11'b0, adx_reg} * {23'b0, p - 11'd1};

    always_comb begin
        case (k_reg)
            2'd0:    dec_sel = mdm_reg;
            2'd1:    dec_sel = pdm_reg;
            default: dec_sel = tr_reg;
        endcase
    end

    assign q      = div_rsp.quotient;
    assign di_cap = (q > {32'b0, DI_MAX}) ? DI_MAX : q[DI_W-1:0];
    assign dx_cap = (q > {57'b0, HUNDRED_FIX}) ? HUNDRED_FIX : q[ADX_W-1:0];

    assign div_state = (state_reg == S_DECAY) || (state_reg == S_DIDIV)
                    || (state_reg == S_DXDIV) || (state_reg == S_ADXDIV)
                    || (state_reg == S_AVGDIV);

    always_comb begin
        div_req.start    = div_state && !issued_reg;
        div_req.dividend = (state_reg == S_DECAY) ? {24'b0, dec_sel} : dvd_reg;
        case (state_reg)
            S_DIDIV: div_req.divisor = tr_reg;
            S_DXDIV: div_req.divisor = {7'b0, sum_reg};
            default: div_req.divisor = {45'b0, p};
        endcase
    end

    avgdx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            k_reg           <= '0;
            issued_reg      <= 1'b0;
            period_reg      <= 11'd14;
            unstable_reg    <= '0;
            last_high_reg   <= '0;
            last_low_reg    <= '0;
            last_close_reg  <= '0;
            bar_counter_reg <= '0;
            mdm_reg         <= '0;
            pdm_reg         <= '0;
            tr_reg          <= '0;
            dx_total_reg    <= '0;
            adx_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_PERIOD) begin
                    period_reg <= cfg_wdata;
                end else if (cfg_index == REG_UNSTABLE) begin
                    unstable_reg <= cfg_wdata[9:0];
                end
            end
            // In the output step the register is reloaded instead.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            if (div_req.start) begin
                issued_reg <= 1'b1;
            end else if (div_rsp.done) begin
                issued_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        hi_reg    <= s_tdata[31:0];
                        lo_reg    <= s_tdata[63:32];
                        cl_reg    <= s_tdata[95:64];
                        idx_reg   <= s_tuser ? 32'd0 : bar_counter_reg;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    k_reg <= '0;
                    if (idx_reg == 32'd0) begin
                        mdm_reg      <= '0;
                        pdm_reg      <= '0;
                        tr_reg       <= '0;
                        dx_total_reg <= '0;
                        adx_reg      <= '0;
                        state_reg    <= S_DONE;
                    end else if (idx_reg >= {21'b0, p}) begin
                        state_reg <= S_DECAY;
                    end else begin
                        state_reg <= S_ADD;
                    end
                end
                S_DECAY: begin
                    if (div_rsp.done) begin
                        case (k_reg)
                            2'd0:    mdm_reg <= mdm_reg - q[SUM_W-1:0];
                            2'd1:    pdm_reg <= pdm_reg - q[SUM_W-1:0];
                            default: tr_reg  <= tr_reg - q[SUM_W-1:0];
                        endcase
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd2) begin
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    if (dm > 0 && dp < dm) begin
                        mdm_reg <= add_m[SUM_W] ? SMOOTH_MAX : add_m[SUM_W-1:0];
                    end else if (dp > 0 && dp > dm) begin
                        pdm_reg <= add_p[SUM_W] ? SMOOTH_MAX : add_p[SUM_W-1:0];
                    end
                    tr_reg    <= add_t[SUM_W] ? SMOOTH_MAX : add_t[SUM_W-1:0];
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    k_reg <= '0;
                    if (idx_reg >= {21'b0, p} && tr_reg != '0) begin
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_MUL: begin
                    dvd_reg   <= {1'b0, prod, 16'b0};
                    state_reg <= (k_reg == 2'd2) ? S_DXDIV : S_DIDIV;
                end
                S_DIDIV: begin
                    if (div_rsp.done) begin
                        if (k_reg == 2'd0) begin
                            mdi_reg   <= di_cap;
                            k_reg     <= 2'd1;
                            state_reg <= S_MUL;
                        end else begin
                            pdi_reg   <= di_cap;
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    sum_reg  <= di_sum;
                    absd_reg <= (mdi_reg >= pdi_reg) ? mdi_reg - pdi_reg : pdi_reg - mdi_reg;
                    k_reg    <= 2'd2;
                    state_reg <= (di_sum == '0) ? S_FIN : S_MUL;
                end
                S_DXDIV: begin
                    if (div_rsp.done) begin
                        if (idx_reg < {20'b0, p, 1'b0}) begin
                            dx_total_reg <= dx_total_reg + {11'b0, dx_cap};
                            state_reg    <= S_FIN;
                        end else begin
                            dx_reg    <= dx_cap;
                            state_reg <= S_ADXMUL;
                        end
                    end
                end
                S_ADXMUL: begin
                    dvd_reg   <= {46'b0, adx_mul} + {57'b0, dx_reg};
                    state_reg <= S_ADXDIV;
                end
                S_ADXDIV: begin
                    if (div_rsp.done) begin
                        adx_reg   <= q[ADX_W-1:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    dvd_reg <= {46'b0, dx_total_reg};
                    state_reg <= (idx_reg == {20'b0, p2m1}) ? S_AVGDIV : S_DONE;
                end
                S_AVGDIV: begin
                    if (div_rsp.done) begin
                        adx_reg   <= q[ADX_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    last_high_reg   <= hi_reg;
                    last_low_reg    <= lo_reg;
                    last_close_reg  <= cl_reg;
                    bar_counter_reg <= (idx_reg == INDEX_MAX) ? INDEX_MAX : idx_reg + 32'd1;
                    state_reg <= (idx_reg >= {20'b0, thr}) ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_adx_reg  <= adx_reg;
                        out_idx_reg  <= idx_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_idx_reg, out_adx_reg};

    a_done_when_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> issued_reg) else $error("division result without a request");
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second bar taken while busy");
    a_bar_zero_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_START && idx_reg == 32'd0) |=> state_reg == S_DONE)
        else $error("bar zero did not finish directly");
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output step");

endmodule
